[rtl/core/matrix_inverse_gauss_jordan_assert.svh]
// ----------------------------------------------------------------------------
// matrix inverter assertion macros
// immediate-consequence and next-cycle property forms
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_GAUSS_JORDAN_ASSERT_SVH
`define MATRIX_INVERSE_GAUSS_JORDAN_ASSERT_SVH

// consequence holds in the same cycle
`define MIG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("matrix inverter check failed");

// consequence holds in the next cycle
`define MIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("matrix inverter check failed");

`endif

[rtl/core/mig_pkg.sv]
// ----------------------------------------------------------------------------
// mig_pkg
// shared constants, datapath command and status types
// ----------------------------------------------------------------------------
package mig_pkg;

	localparam int DATA_W        = 32;
	localparam int CFG_W         = 4;
	localparam int MAX_SIZE_DEF  = 8;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

	// write data source of the matrix memory
	typedef enum logic [2:0] {
		WS_IN   = 3'd0,
		WS_ONE  = 3'd1,
		WS_ZERO = 3'd2,
		WS_A    = 3'd3,
		WS_B    = 3'd4,
		WS_DIV  = 3'd5,
		WS_SUB  = 3'd6
	} wsel_t;

	typedef struct packed {
		logic  rd;
		logic  wr;
		wsel_t wsel;
		logic  mag_load;
		logic  mag_cmp;
		logic  piv_load;
		logic  mult_load;
		logic  mul_en;
		logic  div_start;
		logic  out_zero;
	} cmd_t;

	typedef struct packed {
		logic mag_gt;
		logic piv_zero;
		logic div_done;
	} stat_t;

endpackage

[rtl/core/mig_div.sv]
// ----------------------------------------------------------------------------
// mig_div
// bit-serial signed fixed-point divider, (a << FRAC_BITS) / d, saturated
// ----------------------------------------------------------------------------
module mig_div #(
	parameter int FRAC_BITS = mig_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [mig_pkg::DATA_W-1:0] dividend,
	input  logic signed [mig_pkg::DATA_W-1:0] divisor,
	output logic                              done,
	output logic signed [mig_pkg::DATA_W-1:0] quotient
);
	import mig_pkg::*;

	localparam int NW = DATA_W + FRAC_BITS;
	localparam int CW = $clog2(NW);

	logic [DATA_W-1:0] amag, dmag_in, dmag_q, rem_q;
	logic [NW-1:0]     num_q;
	logic              neg_q, busy_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W:0]   trial, diff;
	logic              fits, over_pos, over_neg;

	assign amag    = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
	assign dmag_in = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, dmag_q};
	assign fits  = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where numerator bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {amag, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			dmag_q <= dmag_in;
			neg_q  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	assign over_pos = |num_q[NW-1:DATA_W-1];
	assign over_neg = (|num_q[NW-1:DATA_W]) || (num_q[DATA_W-1] && (|num_q[DATA_W-2:0]));

	always_comb begin
		if (neg_q)
			quotient = over_neg ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed(num_q[DATA_W-1:0]);
		else
			quotient = over_pos ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(num_q[DATA_W-1:0]);
	end

	assign done = done_q;

endmodule

[rtl/core/mig_datapath.sv]
// ----------------------------------------------------------------------------
// mig_datapath
// matrix memory, pivot and multiplier registers, multiply-subtract, divider
// ----------------------------------------------------------------------------
module mig_datapath #(
	parameter int MAX_SIZE  = mig_pkg::MAX_SIZE_DEF,
	parameter int FRAC_BITS = mig_pkg::FRAC_BITS_DEF,
	parameter int AW        = 2 * $clog2(MAX_SIZE) + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mig_pkg::cmd_t                     cmd,
	input  logic [AW-1:0]                     rd_a_addr,
	input  logic [AW-1:0]                     rd_b_addr,
	input  logic [AW-1:0]                     wr_addr,
	input  logic [mig_pkg::DATA_W-1:0]        in_data,
	output mig_pkg::stat_t                    stat,
	output logic [mig_pkg::DATA_W-1:0]        out_data
);
	import mig_pkg::*;

	localparam int DEPTH = 2 ** AW;
	localparam int PW    = 2 * DATA_W;

	// work matrix in the lower half, inverse in the upper half
	logic [DATA_W-1:0] mem [DEPTH];

	logic signed [DATA_W-1:0] rda_q, rdb_q, piv_q, mult_q, quo;
	logic        [DATA_W-1:0] best_mag_q, amag, one_c, wdata, sub_sat;
	logic signed [PW-1:0]     prod_s1, prod_sh;
	logic signed [PW:0]       diff;
	logic                     diff_fits, div_done;

	assign one_c = DATA_W'(64'd1 << FRAC_BITS);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rda_q <= mem[rd_a_addr];
			rdb_q <= mem[rd_b_addr];
		end
		if (cmd.wr)
			mem[wr_addr] <= wdata;
	end

	assign amag = rda_q[DATA_W-1] ? DATA_W'(-rda_q) : DATA_W'(rda_q);

	always_ff @(posedge clk) begin
		if (cmd.mag_load || (cmd.mag_cmp && stat.mag_gt))
			best_mag_q <= amag;
		if (cmd.piv_load)
			piv_q <= rda_q;
		if (cmd.mult_load)
			mult_q <= rda_q;
		if (cmd.mul_en)
			prod_s1 <= mult_q * rdb_q;
	end

	// arithmetic shift floors the product
	assign prod_sh   = prod_s1 >>> FRAC_BITS;
	assign diff      = (PW + 1)'(rda_q) - (PW + 1)'(prod_sh);
	assign diff_fits = (diff[PW:DATA_W-1] == '0) || (diff[PW:DATA_W-1] == '1);
	assign sub_sat   = diff_fits ? diff[DATA_W-1:0]
		: (diff[PW] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});

	mig_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(rda_q),
		.divisor (piv_q),
		.done    (div_done),
		.quotient(quo)
	);

	always_comb begin
		case (cmd.wsel)
			WS_IN:   wdata = in_data;
			WS_ONE:  wdata = one_c;
			WS_ZERO: wdata = '0;
			WS_A:    wdata = rda_q;
			WS_B:    wdata = rdb_q;
			WS_DIV:  wdata = quo;
			WS_SUB:  wdata = sub_sat;
			default: wdata = '0;
		endcase
	end

	assign stat.mag_gt   = amag > best_mag_q;
	assign stat.piv_zero = rda_q == '0;
	assign stat.div_done = div_done;

	assign out_data = cmd.out_zero ? '0 : rda_q;

endmodule

[rtl/core/mig_ctrl.sv]
// ----------------------------------------------------------------------------
// mig_ctrl
// sequencer for load, pivot search, row swap, normalize, eliminate, output
// ----------------------------------------------------------------------------
module mig_ctrl #(
	parameter int MAX_SIZE = mig_pkg::MAX_SIZE_DEF,
	parameter int AW       = 2 * $clog2(MAX_SIZE) + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [mig_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic                       m_tlast,
	output logic                       m_tuser,
	output mig_pkg::cmd_t              cmd,
	output logic [AW-1:0]              rd_a_addr,
	output logic [AW-1:0]              rd_b_addr,
	output logic [AW-1:0]              wr_addr,
	input  mig_pkg::stat_t             stat
);
	import mig_pkg::*;

	localparam int RW = $clog2(MAX_SIZE);
	localparam int SW = $clog2(MAX_SIZE + 1);

	typedef enum logic [21:0] {
		S_LOAD     = 22'd1,
		S_INIT     = 22'd2,
		S_SRCH_RD  = 22'd4,
		S_SRCH_EX  = 22'd8,
		S_SWP_RD   = 22'd16,
		S_SWP_W1   = 22'd32,
		S_SWP_W2   = 22'd64,
		S_PIV_RD   = 22'd128,
		S_PIV_EX   = 22'd256,
		S_NRM_RD   = 22'd512,
		S_NRM_DIV  = 22'd1024,
		S_NRM_WAIT = 22'd2048,
		S_ROW      = 22'd4096,
		S_ROW_NX   = 22'd8192,
		S_MUL_RD   = 22'd16384,
		S_MUL_LD   = 22'd32768,
		S_ELM_RD   = 22'd65536,
		S_ELM_MUL  = 22'd131072,
		S_ELM_WR   = 22'd262144,
		S_OUT_RD   = 22'd524288,
		S_OUT_V    = 22'd1048576,
		S_SING     = 22'd2097152
	} state_t;

	state_t           state_q, state_d;
	logic [CFG_W-1:0] size_q;
	logic [SW-1:0]    n_eff;
	logic [RW-1:0]    nm1;
	logic [RW-1:0]    row_q, row_d, col_q, col_d, i_q, i_d, best_q, best_d;
	logic             sel_q, sel_d;
	logic             col_end, row_end, i_end;

	always_comb begin
		if (size_q == '0)
			n_eff = SW'(1);
		else if (int'(size_q) > MAX_SIZE)
			n_eff = SW'(MAX_SIZE);
		else
			n_eff = SW'(size_q);
	end

	assign nm1     = RW'(n_eff - 1'b1);
	assign col_end = col_q == nm1;
	assign row_end = row_q == nm1;
	assign i_end   = i_q == nm1;

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		i_d       = i_q;
		best_d    = best_q;
		sel_d     = sel_q;
		cmd       = '0;
		cmd.wsel  = WS_IN;
		rd_a_addr = {1'b0, row_q, col_q};
		rd_b_addr = {1'b0, row_q, col_q};
		wr_addr   = {1'b0, row_q, col_q};
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		m_tlast   = 1'b0;
		m_tuser   = 1'b0;
		case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.wr = 1'b1;
					if (col_end) begin
						col_d = '0;
						if (row_end) begin
							row_d   = '0;
							state_d = S_INIT;
						end else begin
							row_d = row_q + 1'b1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			S_INIT: begin
				cmd.wr   = 1'b1;
				cmd.wsel = (row_q == col_q) ? WS_ONE : WS_ZERO;
				wr_addr  = {1'b1, row_q, col_q};
				if (col_end) begin
					col_d = '0;
					if (row_end) begin
						row_d   = '0;
						i_d     = '0;
						best_d  = '0;
						state_d = S_SRCH_RD;
					end else begin
						row_d = row_q + 1'b1;
					end
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			S_SRCH_RD: begin
				cmd.rd    = 1'b1;
				rd_a_addr = {1'b0, row_q, i_q};
				state_d   = S_SRCH_EX;
			end
			S_SRCH_EX: begin
				if (row_q == i_q) begin
					cmd.mag_load = 1'b1;
				end else begin
					cmd.mag_cmp = 1'b1;
					if (stat.mag_gt)
						best_d = row_q;
				end
				if (row_end) begin
					col_d = '0;
					sel_d = 1'b0;
					state_d = (best_d != i_q) ? S_SWP_RD : S_PIV_RD;
				end else begin
					row_d   = row_q + 1'b1;
					state_d = S_SRCH_RD;
				end
			end
			S_SWP_RD: begin
				cmd.rd    = 1'b1;
				rd_a_addr = {sel_q, i_q, col_q};
				rd_b_addr = {sel_q, best_q, col_q};
				state_d   = S_SWP_W1;
			end
			S_SWP_W1: begin
				cmd.wr   = 1'b1;
				cmd.wsel = WS_B;
				wr_addr  = {sel_q, i_q, col_q};
				state_d  = S_SWP_W2;
			end
			S_SWP_W2: begin
				cmd.wr   = 1'b1;
				cmd.wsel = WS_A;
				wr_addr  = {sel_q, best_q, col_q};
				state_d  = S_SWP_RD;
				if (col_end) begin
					col_d = '0;
					if (sel_q)
						state_d = S_PIV_RD;
					else
						sel_d = 1'b1;
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			S_PIV_RD: begin
				cmd.rd    = 1'b1;
				rd_a_addr = {1'b0, i_q, i_q};
				state_d   = S_PIV_EX;
			end
			S_PIV_EX: begin
				cmd.piv_load = 1'b1;
				col_d = '0;
				sel_d = 1'b0;
				state_d = stat.piv_zero ? S_SING : S_NRM_RD;
			end
			S_NRM_RD: begin
				cmd.rd    = 1'b1;
				rd_a_addr = {sel_q, i_q, col_q};
				state_d   = S_NRM_DIV;
			end
			S_NRM_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = S_NRM_WAIT;
			end
			S_NRM_WAIT: begin
				wr_addr  = {sel_q, i_q, col_q};
				cmd.wsel = WS_DIV;
				if (stat.div_done) begin
					cmd.wr  = 1'b1;
					state_d = S_NRM_RD;
					if (col_end) begin
						col_d = '0;
						if (sel_q) begin
							row_d   = '0;
							state_d = S_ROW;
						end else begin
							sel_d = 1'b1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			S_ROW: begin
				state_d = (row_q == i_q) ? S_ROW_NX : S_MUL_RD;
			end
			S_ROW_NX: begin
				if (row_end) begin
					if (i_end) begin
						row_d   = '0;
						col_d   = '0;
						state_d = S_OUT_RD;
					end else begin
						i_d     = i_q + 1'b1;
						row_d   = i_q + 1'b1;
						best_d  = i_q + 1'b1;
						state_d = S_SRCH_RD;
					end
				end else begin
					row_d   = row_q + 1'b1;
					state_d = S_ROW;
				end
			end
			S_MUL_RD: begin
				cmd.rd    = 1'b1;
				rd_a_addr = {1'b0, row_q, i_q};
				state_d   = S_MUL_LD;
			end
			S_MUL_LD: begin
				cmd.mult_load = 1'b1;
				col_d   = i_q;
				sel_d   = 1'b0;
				state_d = S_ELM_RD;
			end
			S_ELM_RD: begin
				cmd.rd    = 1'b1;
				rd_a_addr = {sel_q, row_q, col_q};
				rd_b_addr = {sel_q, i_q, col_q};
				state_d   = S_ELM_MUL;
			end
			S_ELM_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_ELM_WR;
			end
			S_ELM_WR: begin
				cmd.wr   = 1'b1;
				cmd.wsel = WS_SUB;
				wr_addr  = {sel_q, row_q, col_q};
				state_d  = S_ELM_RD;
				if (col_end) begin
					col_d = '0;
					if (sel_q)
						state_d = S_ROW_NX;
					else
						sel_d = 1'b1;
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			S_OUT_RD: begin
				cmd.rd    = 1'b1;
				rd_a_addr = {1'b1, row_q, col_q};
				state_d   = S_OUT_V;
			end
			S_OUT_V: begin
				m_tvalid = 1'b1;
				m_tlast  = row_end && col_end;
				if (m_tready) begin
					state_d = S_OUT_RD;
					if (col_end) begin
						col_d = '0;
						if (row_end) begin
							row_d   = '0;
							state_d = S_LOAD;
						end else begin
							row_d = row_q + 1'b1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			S_SING: begin
				m_tvalid     = 1'b1;
				m_tlast      = 1'b1;
				m_tuser      = 1'b1;
				cmd.out_zero = 1'b1;
				if (m_tready) begin
					row_d   = '0;
					col_d   = '0;
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			size_q  <= SIZE_RESET;
			row_q   <= '0;
			col_q   <= '0;
			i_q     <= '0;
			best_q  <= '0;
			sel_q   <= 1'b0;
		end else if (cfg_valid) begin
			// new size drops a partly loaded matrix
			size_q  <= cfg_data;
			state_q <= S_LOAD;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			i_q     <= i_d;
			best_q  <= best_d;
			sel_q   <= sel_d;
		end
	end

endmodule

[rtl/core/matrix_inverse_gauss_jordan.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_jordan
// square matrix inverter, gauss-jordan with partial pivoting, signed fixed point
//
//   channel  dir  word                                       handshake
//   cfg      in   cfg_data = matrix size                     cfg_valid / cfg_ready
//   s        in   s_tdata = element value                    s_tvalid / s_tready
//   m        out  m_tdata = inverse value, m_tuser = singular m_tvalid / m_tready
//
// loading accepts one element per cycle, N*N elements per matrix
// inversion then runs on one shared memory read-modify-write path and a
// bit-serial divider
// each result word is read, then offered; a stalled word holds
// no clearing pass after reset; loading is ready from the first cycle
// ----------------------------------------------------------------------------
module matrix_inverse_gauss_jordan #(
	parameter int MAX_SIZE  = mig_pkg::MAX_SIZE_DEF,
	parameter int FRAC_BITS = mig_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mig_pkg::CFG_W-1:0]        cfg_data,   // matrix_size
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mig_pkg::DATA_W-1:0]       s_tdata,    // element_value
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mig_pkg::DATA_W-1:0]       m_tdata,    // inverse_value
	output logic                             m_tlast,
	output logic                             m_tuser     // singular
);
	import mig_pkg::*;

	localparam int AW = 2 * $clog2(MAX_SIZE) + 1;

	cmd_t          cmd;
	stat_t         stat;
	logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;

	assign cfg_ready = 1'b1;

	mig_ctrl #(
		.MAX_SIZE(MAX_SIZE),
		.AW      (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.rd_a_addr(rd_a_addr),
		.rd_b_addr(rd_b_addr),
		.wr_addr  (wr_addr),
		.stat     (stat)
	);

	mig_datapath #(
		.MAX_SIZE (MAX_SIZE),
		.FRAC_BITS(FRAC_BITS),
		.AW       (AW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_a_addr(rd_a_addr),
		.rd_b_addr(rd_b_addr),
		.wr_addr  (wr_addr),
		.in_data  (s_tdata),
		.stat     (stat),
		.out_data (m_tdata)
	);

endmodule

[rtl/core/mig_checker.sv]
// ----------------------------------------------------------------------------
// mig_port_checks
// port-level checks of the matrix inverter, bound to the top level
// ----------------------------------------------------------------------------
`include "matrix_inverse_gauss_jordan_assert.svh"

module mig_port_checks (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [mig_pkg::DATA_W-1:0] m_tdata,
	input logic                       m_tlast,
	input logic                       m_tuser
);
	import mig_pkg::*;

	// a singular result is the only word of its run and carries zero
	`MIG_ASSERT_NOW(a_sing_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	`MIG_ASSERT_NOW(a_sing_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	// loading and emitting never overlap
	`MIG_ASSERT_NOW(a_no_overlap, clk, arst_n, s_tready, !m_tvalid)
	// after the final word the block loads again
	`MIG_ASSERT_NEXT(a_back_to_load, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready)
	`MIG_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind matrix_inverse_gauss_jordan mig_port_checks u_mig_port_checks (.*);
